[src/igmv_pkg.sv]
// ----------------------------------------------------------------------------
// igmv_pkg
// Shared widths, codes and types of the grouped int4 matrix-vector dot block.
// ----------------------------------------------------------------------------
package igmv_pkg;

    localparam int DEF_MAX_COLS = 4096;
    localparam int LANES        = 2;

    localparam int COL_W    = 13;
    localparam int ROW_W    = 16;
    localparam int IDX_W    = 12;
    localparam int ACT_W    = 16;
    localparam int BYTE_W   = 8;
    localparam int SCALE_W  = 16;
    localparam int ZERO_W   = 8;
    localparam int NIB_W    = 4;
    localparam int DIFF_W   = 9;
    localparam int PROD_W   = DIFF_W + SCALE_W;
    localparam int TERM_W   = PROD_W + ACT_W;
    localparam int ACC_W    = 51;
    localparam int SUM_W    = 52;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 72;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_NUM_COLS   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GROUP_SIZE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_ROWS   = 2'd2;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_WEIGHT = 1'b1;

    localparam logic [BYTE_W-1:0] NIBBLE_MASK  = 8'h0F;
    localparam int                NIBBLE_SHIFT = 4;

    localparam logic [COL_W-1:0] RST_NUM_COLS   = 13'd4096;
    localparam logic [COL_W-1:0] RST_GROUP_SIZE = 13'd128;
    localparam logic [ROW_W-1:0] RST_NUM_ROWS   = 16'd1;

    // control that travels down the pipeline beside each weight request
    typedef struct packed {
        logic             in_limit;
        logic             last;
        logic [ROW_W-1:0] row_idx;
    } tag_t;

endpackage

[src/igmv_limit_div.sv]
// ----------------------------------------------------------------------------
// igmv_limit_div
// Restoring divider, one bit a cycle: end of the last full group in a row,
// cols - (cols mod grp).
// ----------------------------------------------------------------------------
module igmv_limit_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [igmv_pkg::COL_W-1:0]  cols,
    input  logic [igmv_pkg::COL_W-1:0]  grp,
    output logic                        busy,
    output logic [igmv_pkg::COL_W-1:0]  limit
);

    localparam int STEPS = igmv_pkg::COL_W;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [igmv_pkg::COL_W-1:0] cols_reg;
    logic [igmv_pkg::COL_W-1:0] grp_reg;
    logic [igmv_pkg::COL_W-1:0] dvd_reg;
    logic [igmv_pkg::COL_W-1:0] rem_reg;
    logic [igmv_pkg::COL_W-1:0] rem_next;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic [igmv_pkg::COL_W:0]   trial;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[igmv_pkg::COL_W-1]};
        if (trial >= {1'b0, grp_reg})
        begin
            rem_next = igmv_pkg::COL_W'(trial - {1'b0, grp_reg});
        end
        else
        begin
            rem_next = trial[igmv_pkg::COL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cols_reg <= cols;
            grp_reg  <= grp;
            dvd_reg  <= cols;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[igmv_pkg::COL_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign busy  = busy_reg;
    assign limit = cols_reg - rem_reg;

endmodule

[src/igmv_lane.sv]
// ----------------------------------------------------------------------------
// igmv_lane
// One weight lane: its bank of the activation store, dequantize, and the
// product with the activation over two multiplier stages.
// ----------------------------------------------------------------------------
module igmv_lane #(
    parameter  int BANK_DEPTH = igmv_pkg::DEF_MAX_COLS / 2,
    localparam int ADDR_W     = $clog2(BANK_DEPTH)
)
(
    input  logic                                clk,
    input  logic                                en,
    input  logic                                we,
    input  logic [ADDR_W-1:0]                   waddr,
    input  logic [igmv_pkg::ACT_W-1:0]          wdata,
    input  logic [ADDR_W-1:0]                   raddr,
    input  logic [igmv_pkg::NIB_W-1:0]          nibble,
    input  logic signed [igmv_pkg::SCALE_W-1:0] scale,
    input  logic [igmv_pkg::ZERO_W-1:0]         zero,
    output logic signed [igmv_pkg::TERM_W-1:0]  term
);

    logic [igmv_pkg::ACT_W-1:0] mem [BANK_DEPTH];

    logic signed [igmv_pkg::ACT_W-1:0]   act_reg;
    logic signed [igmv_pkg::ACT_W-1:0]   act_d_reg;
    logic [igmv_pkg::NIB_W-1:0]          nib_reg;
    logic signed [igmv_pkg::SCALE_W-1:0] scale_reg;
    logic [igmv_pkg::ZERO_W-1:0]         zero_reg;
    logic signed [igmv_pkg::DIFF_W-1:0]  diff;
    logic signed [igmv_pkg::PROD_W-1:0]  prod_next;
    logic signed [igmv_pkg::PROD_W-1:0]  prod_reg;
    logic signed [igmv_pkg::TERM_W-1:0]  term_next;
    logic signed [igmv_pkg::TERM_W-1:0]  term_reg;

    // nibble moves to q4.4 before the zero point comes off
    assign diff      = $signed({1'b0, nib_reg, 4'b0000}) - $signed({1'b0, zero_reg});
    assign prod_next = diff * scale_reg;
    assign term_next = prod_reg * act_d_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (en)
        begin
            act_reg   <= mem[raddr];
            nib_reg   <= nibble;
            scale_reg <= scale;
            zero_reg  <= zero;
            prod_reg  <= prod_next;
            act_d_reg <= act_reg;
            term_reg  <= term_next;
        end
    end

    assign term = term_reg;

endmodule

[src/int4_grouped_matrix_vector_dot.sv]
// ----------------------------------------------------------------------------
// int4_grouped_matrix_vector_dot
// Grouped int4 matrix-vector dot product with exact fixed-point accumulation.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel: tuser is the opcode. A load request
// writes one q3.12 activation; a weight request carries one byte with two
// int4 weights, the even column in the low nibble. Each weight byte feeds
// two lanes, one per nibble, each with its own bank of the activation
// store, and a merge stage adds both terms into the row accumulator.
// Each row gives one result (row sum, row index) on m_. Throughput is one
// request per cycle, loads and weights alike, while s_tready is high. A
// row's last request passes s1, s2, s3 and the merge stage to the output
// register. After reset and each cfg write, s_tready is low while a
// bit-serial divider computes the end of the last full group. Reset
// clears counters, accumulator and held scale and zero; activations are
// undefined until loaded. When the receiver stalls, the result waits in
// the output register; requests keep flowing until the next finished row
// reaches the merge stage, which then holds the pipeline.
// ----------------------------------------------------------------------------
module int4_grouped_matrix_vector_dot #(
    parameter int MAX_COLS = igmv_pkg::DEF_MAX_COLS
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // act_index[11:0], act_value[27:12], weight_byte[35:28], scale[51:36],
    // zero_point[59:52], zero fill [63:60]
    input  logic [igmv_pkg::IN_DATA_W-1:0]        s_tdata,
    // opcode[0]
    input  logic                                  s_tuser,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // row_sum[51:0], row_index[67:52], zero fill [71:68]
    output logic [igmv_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [igmv_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [igmv_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int BANK_DEPTH = (MAX_COLS + 1) / 2;
    localparam int BA_W       = $clog2(BANK_DEPTH);
    localparam int MAX_EVEN   = MAX_COLS - (MAX_COLS % 2);

    localparam int COL_W = igmv_pkg::COL_W;
    localparam int ROW_W = igmv_pkg::ROW_W;

    // request fields
    logic [igmv_pkg::IDX_W-1:0]          in_idx;
    logic [igmv_pkg::ACT_W-1:0]          in_act;
    logic [igmv_pkg::BYTE_W-1:0]         in_byte;
    logic signed [igmv_pkg::SCALE_W-1:0] in_scale;
    logic [igmv_pkg::ZERO_W-1:0]         in_zero;

    assign in_idx   = s_tdata[11:0];
    assign in_act   = s_tdata[27:12];
    assign in_byte  = s_tdata[35:28];
    assign in_scale = $signed(s_tdata[51:36]);
    assign in_zero  = s_tdata[59:52];

    // configuration
    logic [COL_W-1:0] num_cols_reg;
    logic [COL_W-1:0] group_size_reg;
    logic [ROW_W-1:0] num_rows_reg;
    logic             start_reg;
    logic             cfg_accept;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg   <= igmv_pkg::RST_NUM_COLS;
            group_size_reg <= igmv_pkg::RST_GROUP_SIZE;
            num_rows_reg   <= igmv_pkg::RST_NUM_ROWS;
            start_reg      <= 1'b1;
        end
        else
        begin
            start_reg <= cfg_accept;
            if (cfg_accept)
            begin
                case (cfg_addr)
                    igmv_pkg::REG_NUM_COLS:   num_cols_reg   <= cfg_data[COL_W-1:0];
                    igmv_pkg::REG_GROUP_SIZE: group_size_reg <= cfg_data[COL_W-1:0];
                    igmv_pkg::REG_NUM_ROWS:   num_rows_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // effective sizes: even, at least two, columns clamped to the store
    logic [COL_W-1:0] cols_even;
    logic [COL_W-1:0] grp_even;
    logic [COL_W-1:0] cols;
    logic [COL_W-1:0] grp;

    always_comb
    begin
        cols_even = {num_cols_reg[COL_W-1:1], 1'b0};
        grp_even  = {group_size_reg[COL_W-1:1], 1'b0};
        cols      = (cols_even < COL_W'(2)) ? COL_W'(2) : cols_even;
        if (32'(cols) > MAX_COLS)
        begin
            cols = COL_W'(MAX_EVEN);
        end
        grp = (grp_even < COL_W'(2)) ? COL_W'(2) : grp_even;
    end

    logic             div_busy;
    logic [COL_W-1:0] limit;

    igmv_limit_div u_limit (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .cols  (cols),
        .grp   (grp),
        .busy  (div_busy),
        .limit (limit)
    );

    // pipeline control
    logic                  s1_valid_reg, s2_valid_reg, s3_valid_reg;
    igmv_pkg::tag_t        s1_tag_reg, s2_tag_reg, s3_tag_reg;
    igmv_pkg::tag_t        s0_tag;
    logic                  out_valid_reg;
    logic                  en;
    logic                  accept;
    logic                  w_acc;
    logic                  l_acc;

    // hold only when a finished row cannot leave the merge stage
    assign en       = !(s3_valid_reg && s3_tag_reg.last && out_valid_reg && !m_tready);
    assign s_tready = en && !div_busy && !start_reg;
    assign accept   = s_tvalid && s_tready;
    assign w_acc    = accept && (s_tuser == igmv_pkg::OP_WEIGHT);
    assign l_acc    = accept && (s_tuser == igmv_pkg::OP_LOAD);

    // row and group bookkeeping
    logic [COL_W-1:0]                    column_count_reg, column_count_next;
    logic [COL_W-1:0]                    group_count_reg, group_count_next;
    logic [ROW_W-1:0]                    row_count_reg, row_count_next;
    logic signed [igmv_pkg::SCALE_W-1:0] held_scale_reg, held_scale_next;
    logic [igmv_pkg::ZERO_W-1:0]         held_zero_reg, held_zero_next;
    logic signed [igmv_pkg::SCALE_W-1:0] cur_scale;
    logic [igmv_pkg::ZERO_W-1:0]         cur_zero;
    logic [COL_W-1:0]                    cc_inc;
    logic [COL_W-1:0]                    gc_inc;
    logic [ROW_W-1:0]                    rc_inc;
    logic                                grp_first;

    always_comb
    begin
        grp_first = (group_count_reg == '0);
        cur_scale = grp_first ? in_scale : held_scale_reg;
        cur_zero  = grp_first ? in_zero : held_zero_reg;
        cc_inc    = column_count_reg + COL_W'(2);
        gc_inc    = group_count_reg + COL_W'(2);
        rc_inc    = row_count_reg + ROW_W'(1);

        s0_tag.in_limit = (column_count_reg < limit);
        s0_tag.last     = (cc_inc >= cols);
        s0_tag.row_idx  = row_count_reg;

        column_count_next = column_count_reg;
        group_count_next  = group_count_reg;
        row_count_next    = row_count_reg;
        held_scale_next   = held_scale_reg;
        held_zero_next    = held_zero_reg;

        if (w_acc)
        begin
            held_scale_next   = cur_scale;
            held_zero_next    = cur_zero;
            column_count_next = cc_inc;
            group_count_next  = (gc_inc >= grp) ? '0 : gc_inc;
            if (s0_tag.last)
            begin
                column_count_next = '0;
                group_count_next  = '0;
                row_count_next    = (rc_inc >= num_rows_reg) ? '0 : rc_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            group_count_reg  <= '0;
            row_count_reg    <= '0;
            held_scale_reg   <= '0;
            held_zero_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            group_count_reg  <= group_count_next;
            row_count_reg    <= row_count_next;
            held_scale_reg   <= held_scale_next;
            held_zero_reg    <= held_zero_next;
            if (en)
            begin
                s1_valid_reg <= w_acc;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_tag_reg <= s0_tag;
            s2_tag_reg <= s1_tag_reg;
            s3_tag_reg <= s2_tag_reg;
        end
    end

    // lanes: lane 0 takes even columns, lane 1 odd columns
    logic                               load_ok;
    logic [BA_W-1:0]                    load_addr;
    logic [BA_W-1:0]                    read_addr;
    logic [igmv_pkg::NIB_W-1:0]         nib [igmv_pkg::LANES];
    logic signed [igmv_pkg::TERM_W-1:0] term [igmv_pkg::LANES];

    assign load_ok   = l_acc && (32'(in_idx) < MAX_COLS);
    assign load_addr = BA_W'(in_idx >> 1);
    assign read_addr = BA_W'(column_count_reg >> 1);
    assign nib[0]    = igmv_pkg::NIB_W'(in_byte & igmv_pkg::NIBBLE_MASK);
    assign nib[1]    = igmv_pkg::NIB_W'((in_byte >> igmv_pkg::NIBBLE_SHIFT)
                                        & igmv_pkg::NIBBLE_MASK);

    for (genvar g = 0; g < igmv_pkg::LANES; g++)
    begin : g_lane
        igmv_lane #(
            .BANK_DEPTH (BANK_DEPTH)
        ) u_lane (
            .clk    (clk),
            .en     (en),
            .we     (load_ok && (in_idx[0] == 1'(g))),
            .waddr  (load_addr),
            .wdata  (in_act),
            .raddr  (read_addr),
            .nibble (nib[g]),
            .scale  (cur_scale),
            .zero   (cur_zero),
            .term   (term[g])
        );
    end

    // merge stage
    logic signed [igmv_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic signed [igmv_pkg::ACC_W-1:0]  acc_sum;
    logic signed [igmv_pkg::TERM_W-1:0] t0, t1;
    logic                               merge;
    logic [igmv_pkg::SUM_W-1:0]         out_sum_reg;
    logic [ROW_W-1:0]                   out_idx_reg;

    // columns past the last full group add nothing
    assign t0      = s3_tag_reg.in_limit ? term[0] : '0;
    assign t1      = s3_tag_reg.in_limit ? term[1] : '0;
    assign acc_sum = acc_reg + t0 + t1;
    assign merge   = en && s3_valid_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (merge)
        begin
            acc_next = s3_tag_reg.last ? '0 : acc_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (merge && s3_tag_reg.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (merge && s3_tag_reg.last)
        begin
            out_sum_reg <= {acc_sum[igmv_pkg::ACC_W-1], acc_sum};
            out_idx_reg <= s3_tag_reg.row_idx;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_idx_reg, out_sum_reg};

    // checks
    a_no_accept_while_dividing: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> (!div_busy && !start_reg))
        else $error("request accepted while group limit is being computed");

    a_column_even: assert property (
        @(posedge clk) disable iff (!rst_n)
        column_count_reg[0] == 1'b0)
        else $error("column count went odd");

    a_acc_cleared_after_row: assert property (
        @(posedge clk) disable iff (!rst_n)
        (merge && s3_tag_reg.last) |=> (acc_reg == '0 && out_valid_reg))
        else $error("accumulator not cleared or result lost at end of row");

    a_hold_keeps_pipe: assert property (
        @(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(s3_valid_reg) && $stable(acc_reg)))
        else $error("merge stage moved while held");

endmodule

[tb/int4_grouped_matrix_vector_dot_test.sv]
// ----------------------------------------------------------------------------
// int4_grouped_matrix_vector_dot_test
// Self-checking bench for the grouped int4 matrix-vector dot block.
// ----------------------------------------------------------------------------
// Activation loads and packed weight bytes stream in on s_; every accepted
// request also goes to a behavioral model of the dot product that keeps its
// own activation store, counters and registers and queues the expected row
// results. Each result leaving m_ is compared against the oldest queued row.
// A directed pass covers field extremes, odd and tiny sizes, partial groups,
// groups wider than the row, row counter wrap and mid-row register changes.
// Random phases follow with bursty requests, receiver stalls and one long
// hold-off, and a last short row is set up with upper register bits set.
// ----------------------------------------------------------------------------
module int4_grouped_matrix_vector_dot_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 360;

    typedef struct packed {
        logic [igmv_pkg::SUM_W-1:0] sum;
        logic [igmv_pkg::ROW_W-1:0] row;
    } row_result_t;

    // behavioral model of the row accumulation plus the queue of rows due
    class gemv_rows;
        logic [igmv_pkg::ACT_W-1:0]   act_mem [igmv_pkg::DEF_MAX_COLS];
        logic [igmv_pkg::ACC_W-1:0]   acc;
        logic [igmv_pkg::COL_W-1:0]   col_cnt;
        logic [igmv_pkg::COL_W-1:0]   grp_cnt;
        logic [igmv_pkg::SCALE_W-1:0] held_scale;
        logic [igmv_pkg::ZERO_W-1:0]  held_zero;
        logic [igmv_pkg::ROW_W-1:0]   row_cnt;
        logic [igmv_pkg::COL_W-1:0]   reg_cols;
        logic [igmv_pkg::COL_W-1:0]   reg_group;
        logic [igmv_pkg::ROW_W-1:0]   reg_rows;
        row_result_t                  rows_due [$];
        int                           mismatches;

        function new();
            acc        = '0;
            col_cnt    = '0;
            grp_cnt    = '0;
            held_scale = '0;
            held_zero  = '0;
            row_cnt    = '0;
            reg_cols   = igmv_pkg::RST_NUM_COLS;
            reg_group  = igmv_pkg::RST_GROUP_SIZE;
            reg_rows   = igmv_pkg::RST_NUM_ROWS;
            mismatches = 0;
        endfunction

        function void set_register(logic [igmv_pkg::CFG_ADDR_W-1:0] addr,
                                   logic [igmv_pkg::CFG_DATA_W-1:0] value);
            case (addr)
                igmv_pkg::REG_NUM_COLS:   reg_cols  = value[igmv_pkg::COL_W-1:0];
                igmv_pkg::REG_GROUP_SIZE: reg_group = value[igmv_pkg::COL_W-1:0];
                igmv_pkg::REG_NUM_ROWS:   reg_rows  = value[igmv_pkg::ROW_W-1:0];
                default:                  ;
            endcase
        endfunction

        function int columns();
            int c;
            c = int'(reg_cols) & ~1;
            if (c < 2)
                c = 2;
            if (c > igmv_pkg::DEF_MAX_COLS)
                c = igmv_pkg::DEF_MAX_COLS;
            return c;
        endfunction

        function int group_len();
            int g;
            g = int'(reg_group) & ~1;
            return (g < 2) ? 2 : g;
        endfunction

        function int pending();
            return rows_due.size();
        endfunction

        // (nibble in q4.4 - zero) * scale * activation, 28 fraction bits
        function longint dequant_term(logic [igmv_pkg::NIB_W-1:0] nib, int col);
            longint d;
            longint s;
            longint a;
            d = {nib, 4'b0000};
            d = d - held_zero;
            s = $signed(held_scale);
            a = $signed(act_mem[col]);
            return d * s * a;
        endfunction

        function void accept_request(logic op, logic [igmv_pkg::IN_DATA_W-1:0] data);
            int                          cols;
            int                          grp;
            int                          full_end;
            logic [igmv_pkg::BYTE_W-1:0] wb;
            row_result_t                 r;
            if (op == igmv_pkg::OP_LOAD)
            begin
                act_mem[data[11:0]] = data[27:12];
                return;
            end
            cols     = columns();
            grp      = group_len();
            full_end = (cols / grp) * grp;
            if (grp_cnt == 0)
            begin
                held_scale = data[51:36];
                held_zero  = data[59:52];
            end
            wb = data[35:28];
            if (col_cnt < full_end)
                acc = acc + dequant_term(wb[3:0], int'(col_cnt))
                          + dequant_term(wb[7:4], int'(col_cnt) + 1);
            col_cnt = col_cnt + igmv_pkg::COL_W'(2);
            grp_cnt = grp_cnt + igmv_pkg::COL_W'(2);
            if (grp_cnt >= grp)
                grp_cnt = '0;
            if (col_cnt < cols)
                return;
            r.sum = {acc[igmv_pkg::ACC_W-1], acc};
            r.row = row_cnt;
            rows_due.push_back(r);
            row_cnt = row_cnt + igmv_pkg::ROW_W'(1);
            if (row_cnt >= reg_rows)
                row_cnt = '0;
            acc     = '0;
            col_cnt = '0;
            grp_cnt = '0;
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got 0x%0h, expected 0x%0h", what, got, want);
            mismatches++;
        endtask

        task check_row(logic [igmv_pkg::OUT_DATA_W-1:0] data);
            row_result_t want;
            if (rows_due.size() == 0)
            begin
                report("unexpected result", data[63:0], 64'd0);
                return;
            end
            want = rows_due.pop_front();
            if (data[51:0] !== want.sum)
                report("row_sum", data[51:0], want.sum);
            if (data[67:52] !== want.row)
                report("row_index", data[67:52], want.row);
            if (data[71:68] !== 4'd0)
                report("zero fill", data[71:68], 64'd0);
        endtask
    endclass

    logic                                clk;
    logic                                rst_n;
    logic [igmv_pkg::IN_DATA_W-1:0]      s_tdata;
    logic                                s_tuser;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [igmv_pkg::OUT_DATA_W-1:0]     m_tdata;
    logic                                m_tvalid;
    logic                                m_tready;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [igmv_pkg::CFG_ADDR_W-1:0]     cfg_addr;
    logic [igmv_pkg::CFG_DATA_W-1:0]     cfg_data;

    gemv_rows board;
    bit       act_loaded [igmv_pkg::DEF_MAX_COLS];
    int       burst_left;
    int       sent_items;
    int       cycle_count;
    bit       hold_req;

    int4_grouped_matrix_vector_dot uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_row(m_tdata);
    end

    // receiver: stall modes that change at random intervals, plus one
    // long hold-off on request
    initial
    begin
        int stall_mode;
        int stall_left;
        int tick;
        stall_mode = 0;
        stall_left = 0;
        tick       = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(16, 128);
            end
            stall_left--;
            tick++;
            case (stall_mode)
                0:       m_tready = 1'b1;
                1:       m_tready = $urandom_range(0, 1);
                2:       m_tready = ($urandom_range(0, 3) == 0);
                default: m_tready = (tick % 3 != 0);
            endcase
        end
    end

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [igmv_pkg::IN_DATA_W-1:0] pack_request(
            logic [igmv_pkg::IDX_W-1:0] idx, logic [igmv_pkg::ACT_W-1:0] val,
            logic [igmv_pkg::BYTE_W-1:0] wb, logic [igmv_pkg::SCALE_W-1:0] sc,
            logic [igmv_pkg::ZERO_W-1:0] zp);
        return {4'b0000, zp, sc, wb, val, idx};
    endfunction

    task send_request(logic op, logic [igmv_pkg::IN_DATA_W-1:0] data);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                burst_left = $urandom_range(16, 64);
                gap        = 0;
            end
            else
            begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(0, 6);
            end
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = data;
        do
            @(posedge clk);
        while (!s_tready);
        board.accept_request(op, data);
        burst_left--;
        sent_items++;
    endtask

    task send_load(logic [igmv_pkg::IDX_W-1:0] idx, logic [igmv_pkg::ACT_W-1:0] val);
        send_request(igmv_pkg::OP_LOAD, pack_request(idx, val, 8'($urandom_range(0, 255)),
                     16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255))));
        act_loaded[idx] = 1'b1;
    endtask

    task send_weight(logic [igmv_pkg::BYTE_W-1:0] wb, logic [igmv_pkg::SCALE_W-1:0] sc,
                     logic [igmv_pkg::ZERO_W-1:0] zp);
        send_request(igmv_pkg::OP_WEIGHT, pack_request(12'($urandom_range(0, 4095)),
                     16'($urandom_range(0, 65535)), wb, sc, zp));
    endtask

    task send_random_weight();
        send_weight(8'($urandom_range(0, 255)), rand_word(), 8'($urandom_range(0, 255)));
    endtask

    // activations that the current row length can read must hold a value
    task load_missing();
        int n;
        n = board.columns();
        for (int i = 0; i < n; i++)
        begin
            if (!act_loaded[i])
                send_load(12'(i), rand_word());
        end
    endtask

    task go_idle();
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task wait_rows_done();
        go_idle();
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // loads in flight give no result, so allow the pipeline to empty too
    task settle();
        wait_rows_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_config(logic [igmv_pkg::CFG_ADDR_W-1:0] addr,
                      logic [igmv_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_addr  = addr;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_register(addr, value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task set_shape(int cols, int grp, int rows);
        write_config(igmv_pkg::REG_NUM_COLS, 16'(cols));
        write_config(igmv_pkg::REG_GROUP_SIZE, 16'(grp));
        write_config(igmv_pkg::REG_NUM_ROWS, 16'(rows));
    endtask

    task directed_pass();
        set_shape(4, 2, 3);
        send_load(12'd0, 16'h7FFF);
        send_load(12'd1, 16'h8000);
        send_load(12'd2, 16'h0000);
        send_load(12'd3, 16'hFFFF);
        send_weight(8'h0F, 16'h7FFF, 8'h00);
        send_weight(8'hF0, 16'h8000, 8'hFF);
        send_weight(8'hFF, 16'h8000, 8'h00);
        send_weight(8'h00, 16'h7FFF, 8'hFF);
        // row 2 left half done, then the row shrinks to the columns already done
        send_weight(8'hA5, 16'h1234, 8'h88);
        settle();
        write_config(igmv_pkg::REG_NUM_COLS, 16'd3);
        write_config(igmv_pkg::REG_NUM_ROWS, 16'd1);
        send_weight(8'h5A, 16'hFEDC, 8'h17);
        send_weight(8'h3C, 16'h0001, 8'hF0);
        settle();
        // tiny sizes and a zero row count
        set_shape(1, 0, 0);
        send_weight(8'h96, 16'h4000, 8'h80);
        send_weight(8'h69, 16'hC000, 8'h7F);
        settle();
        // last group only partly covered; a load in mid-row
        set_shape(6, 4, 65535);
        load_missing();
        send_weight(8'h12, 16'h0800, 8'h10);
        send_load(12'd4095, 16'h8000);
        send_weight(8'h34, 16'hF800, 8'h20);
        send_weight(8'hEF, 16'h7FFF, 8'h00);
        settle();
        // group wider than the row: sums are zero
        set_shape(4, 8, 2);
        send_weight(8'hFF, 16'h7FFF, 8'h00);
        send_weight(8'h77, 16'h8000, 8'hFF);
        settle();
    endtask

    task random_phase(int phase_no);
        int cols_raw;
        int grp_raw;
        int rows_raw;
        int rows_n;
        int per_row;
        if (phase_no == 0)
        begin
            cols_raw = 2;
            grp_raw  = 2;
            rows_raw = 7;
        end
        else
        begin
            case ($urandom_range(0, 7))
                0:       cols_raw = $urandom_range(0, 3);
                1:       cols_raw = $urandom_range(33, 200);
                default: cols_raw = $urandom_range(4, 32);
            endcase
            case ($urandom_range(0, 5))
                0:       grp_raw = 2;
                1:       grp_raw = cols_raw + $urandom_range(1, 20);
                2:       grp_raw = $urandom_range(0, 3);
                default: grp_raw = $urandom_range(2, (cols_raw > 2) ? cols_raw : 2);
            endcase
            case ($urandom_range(0, 5))
                0:       rows_raw = 0;
                1:       rows_raw = 65535;
                2:       rows_raw = 1;
                default: rows_raw = $urandom_range(2, 9);
            endcase
        end
        set_shape(cols_raw, grp_raw, rows_raw);
        load_missing();
        per_row = board.columns() / 2;
        rows_n  = (phase_no == 0) ? 40 : $urandom_range(1, (per_row <= 16) ? 8 : 2);
        // receiver holds off long enough for the block to back up
        if (phase_no == 0)
            hold_req = 1'b1;
        for (int r = 0; r < rows_n; r++)
        begin
            if (phase_no == 2 && r == rows_n / 2)
                wait_rows_done();
            for (int k = 0; k < per_row; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_load(12'($urandom_range(0, 4095)), rand_word());
                send_random_weight();
            end
        end
        // leave a row unfinished now and then across the register change
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, per_row)) send_random_weight();
        settle();
    endtask

    initial
    begin
        int start_items;
        int phase_no;
        board      = new();
        burst_left = 0;
        sent_items = 0;
        cycle_count = 0;
        hold_req   = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tuser    = 1'b0;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_addr   = '0;
        cfg_data   = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        directed_pass();

        start_items = sent_items;
        phase_no    = 0;
        while (sent_items - start_items < RANDOM_ITEMS)
        begin
            random_phase(phase_no);
            phase_no++;
        end

        // one short row; upper data bits of the register are ignored
        write_config(igmv_pkg::REG_NUM_COLS, 16'hE010);
        write_config(igmv_pkg::REG_GROUP_SIZE, 16'd8);
        write_config(igmv_pkg::REG_NUM_ROWS, 16'd1);
        load_missing();
        repeat (8) send_random_weight();

        wait_rows_done();
        repeat (20) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
